FILE: src/vlp_pkg.sv
// Shared constants, codes and control types for the variable-width bit packer.
package vlp_pkg;

    localparam int CWM_DEFAULT  = 24;  // default widest code in bits
    localparam int BYTE_W       = 8;
    localparam int CODE_W_W     = 6;   // code_width field
    localparam int CODE_V_W     = 24;  // code_value field
    localparam int STATUS_W     = 2;
    localparam int PEND_W       = 3;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_PAD_W    = OUT_TDATA_W - BYTE_W - STATUS_W - PEND_W;
    localparam int IN_PAD_W     = IN_TDATA_W - CODE_W_W - CODE_V_W;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_WIDTH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CODE  = 2'd2;

    // request types
    localparam logic REQ_PUT   = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // kind of work latched for the current item
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_FLUSH = 2'd1;
    localparam logic [1:0] KIND_ERR_W = 2'd2;
    localparam logic [1:0] KIND_ERR_C = 2'd3;

    typedef struct packed {
        logic accept;  // latch the input item
        logic step;    // load one result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;    // output register empty or being taken
        logic has_result;  // item on the input causes at least one result
        logic step_last;   // the next result is the last of the item
    } t_dp_status;

endpackage

FILE: src/vlp_datapath.sv
// Datapath of the bit packer: accumulator, input checks and output register.
module vlp_datapath
    import vlp_pkg::*;
#(
    parameter int CODE_WIDTH_MAX = CWM_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_type,
    input  logic [CODE_W_W-1:0]    i_code_width,
    input  logic [CODE_V_W-1:0]    i_code_value,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser,
    output logic                   o_m_tlast
);

    localparam int ACC_W = CODE_WIDTH_MAX + BYTE_W - 1;
    localparam int CNT_W = $clog2(ACC_W + 1);

    // accumulator is MSB aligned: the top r_cnt bits are valid, the rest zero
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [1:0]          r_kind, n_kind;

    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                r_out_bv, n_out_bv;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [PEND_W-1:0]   r_out_pend, n_out_pend;
    logic                r_out_last, n_out_last;

    logic                w_bad_width;
    logic                w_bad_code;
    logic [ACC_W-1:0]    w_code_ext;
    logic [CNT_W-1:0]    w_sum_cnt;
    logic [CNT_W-1:0]    w_shamt;
    logic [ACC_W-1:0]    w_put_acc;
    logic [CNT_W-1:0]    w_cnt_less;

    always_comb begin
        w_bad_width = (i_code_width == '0) ||
                      (i_code_width > CODE_W_W'(CODE_WIDTH_MAX));
        w_bad_code  = (i_code_width < CODE_W_W'(CODE_V_W)) &&
                      ((i_code_value >> i_code_width) != '0);
        w_code_ext  = ACC_W'(i_code_value);
        w_sum_cnt   = r_cnt + CNT_W'(i_code_width);
        w_shamt     = CNT_W'(ACC_W) - w_sum_cnt;
        w_put_acc   = r_acc | (w_code_ext << w_shamt);
        w_cnt_less  = r_cnt - CNT_W'(BYTE_W);
    end

    assign o_status.out_free   = !r_out_valid || i_m_tready;
    assign o_status.has_result = (i_req_type == REQ_FLUSH) || w_bad_width || w_bad_code ||
                                 (w_sum_cnt >= CNT_W'(BYTE_W));
    assign o_status.step_last  = (r_kind != KIND_PUT) || (w_cnt_less < CNT_W'(BYTE_W));

    always_comb begin
        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_kind       = r_kind;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_bv     = r_out_bv;
        n_out_status = r_out_status;
        n_out_pend   = r_out_pend;
        n_out_last   = r_out_last;

        if (i_cmd.accept) begin
            if (i_req_type == REQ_FLUSH) begin
                n_kind = KIND_FLUSH;
            end else if (w_bad_width) begin
                n_kind = KIND_ERR_W;
            end else if (w_bad_code) begin
                n_kind = KIND_ERR_C;
            end else begin
                n_kind = KIND_PUT;
                n_acc  = w_put_acc;
                n_cnt  = w_sum_cnt;
            end
        end

        if (i_cmd.step) begin
            n_out_valid  = 1'b1;
            n_out_byte   = '0;
            n_out_bv     = 1'b0;
            n_out_status = ST_OK;
            n_out_pend   = '0;
            n_out_last   = 1'b1;
            case (r_kind)
                KIND_PUT: begin
                    n_out_byte = r_acc[ACC_W-1 -: BYTE_W];
                    n_out_bv   = 1'b1;
                    n_out_last = (w_cnt_less < CNT_W'(BYTE_W));
                    n_acc      = r_acc << BYTE_W;
                    n_cnt      = w_cnt_less;
                end
                KIND_FLUSH: begin
                    // bits below the count are zero, so the byte is already padded
                    n_out_byte = r_acc[ACC_W-1 -: BYTE_W];
                    n_out_bv   = (r_cnt != '0);
                    n_out_pend = r_cnt[PEND_W-1:0];
                    n_acc      = '0;
                    n_cnt      = '0;
                end
                KIND_ERR_W: begin
                    n_out_status = ST_BAD_WIDTH;
                end
                KIND_ERR_C: begin
                    n_out_status = ST_BAD_CODE;
                end
                default: begin
                    n_out_status = ST_OK;
                end
            endcase
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_out_byte   <= n_out_byte;
        r_out_bv     <= n_out_bv;
        r_out_status <= n_out_status;
        r_out_pend   <= n_out_pend;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_pend, r_out_status, r_out_byte};
    assign o_m_tuser  = r_out_bv;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over an untaken result");

    a_put_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_kind == KIND_PUT) |-> (r_cnt >= CNT_W'(BYTE_W)))
        else $error("byte emitted with fewer than eight bits held");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_kind == KIND_FLUSH) |=> (r_cnt == '0 && r_acc == '0))
        else $error("flush left bits in the accumulator");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept) |-> (r_cnt < CNT_W'(BYTE_W)))
        else $error("item accepted while whole bytes still held");
`endif

endmodule

FILE: src/vlp_ctrl.sv
// Controller of the bit packer: accepts items and sequences result loads.
module vlp_ctrl
    import vlp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state, n_state;
    logic w_accept;

    assign o_s_tready   = (r_state == S_IDLE);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign o_cmd.accept = w_accept;
    assign o_cmd.step   = (r_state == S_EMIT) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_status.has_result) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.step && i_status.step_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/variable_width_bit_packer.sv
// MSB-first variable-width bit packer, top level. An item either appends a code of
// 1 to CODE_WIDTH_MAX bits to the bit stream or flushes the partial byte; every
// completed byte leaves as one result item, and invalid widths or oversize codes give
// a single error result without touching the stream. After an item is taken, the block
// loads one result per cycle, while the output is not stalled, into its single output
// register: a put that completes n bytes gives n results (n at most
// (CODE_WIDTH_MAX + 7) / 8), a flush or an error one result, and a put that completes
// no byte none. A stall on the output holds the loads. The next item is taken as soon
// as the last result of the current one is loaded, even while that result is still
// waiting on the output.
module variable_width_bit_packer
    import vlp_pkg::*;
#(
    parameter int CODE_WIDTH_MAX = CWM_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // code_width[5:0], code_value[29:6], zero
    input  logic                   i_s_tuser,   // req_type
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // out_byte[7:0], status[9:8],
                                                // pending_bits[12:10], zero
    output logic                   o_m_tuser,   // byte_valid
    output logic                   o_m_tlast    // last
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    vlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    vlp_datapath #(
        .CODE_WIDTH_MAX (CODE_WIDTH_MAX)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_s_tuser),
        .i_code_width (i_s_tdata[CODE_W_W-1:0]),
        .i_code_value (i_s_tdata[CODE_W_W +: CODE_V_W]),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

endmodule
